// ===== rtl/cyk_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cyk_pkg
// shared constants, rule entry types and helpers for the cyk recogniser
// ----------------------------------------------------------------------------
package cyk_pkg;

  localparam int MAX_TOKENS    = 32;
  localparam int MAX_VARIABLES = 32;
  localparam int MAX_RULES     = 64;
  localparam int SYMBOL_BITS   = 8;

  localparam int VAR_W   = 5;
  localparam int SYM_IN_W = 8;
  localparam int TOK_AW  = (MAX_TOKENS > 1) ? $clog2(MAX_TOKENS) : 1;
  localparam int TOK_CW  = $clog2(MAX_TOKENS + 1);
  localparam int RULE_AW = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
  localparam int RULE_CW = $clog2(MAX_RULES + 1);
  localparam int CHART_AW = 2 * TOK_AW;

  localparam logic [1:0] OP_LOAD_TERM = 2'd0;
  localparam logic [1:0] OP_LOAD_BIN  = 2'd1;
  localparam logic [1:0] OP_TOKEN     = 2'd2;
  localparam logic [1:0] OP_FINISH    = 2'd3;

  typedef logic [MAX_VARIABLES-1:0] var_set_t;

  typedef struct packed {
    logic [VAR_W-1:0]       head;
    logic [SYMBOL_BITS-1:0] sym;
  } term_rule_t;

  typedef struct packed {
    logic [VAR_W-1:0] head;
    logic [VAR_W-1:0] first;
    logic [VAR_W-1:0] second;
  } bin_rule_t;

  // control of the shared rule unit
  typedef struct packed {
    logic clr;
    logic en;
    logic binary;
  } ru_ctrl_t;

  // one-hot set bit of a variable, empty when out of range
  function automatic var_set_t var_bit(input logic [VAR_W-1:0] v);
    var_set_t s;
    for (int k = 0; k < MAX_VARIABLES; k++) begin
      s[k] = (VAR_W'(k) == v) && (k < (1 << VAR_W));
    end
    return s;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/cyk_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cyk_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module cyk_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

// ===== rtl/cyk_rule_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cyk_rule_unit
// shared rule matcher: tests one rule a step and gathers the cell bit set
// ----------------------------------------------------------------------------
module cyk_rule_unit import cyk_pkg::*; (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire ru_ctrl_t               ctrl_i,
  input  wire logic [SYMBOL_BITS-1:0] token_i,
  input  wire term_rule_t             term_i,
  input  wire bin_rule_t              bin_i,
  input  wire var_set_t               lset_i,
  input  wire var_set_t               rset_i,
  output var_set_t                    cell_o
);

  var_set_t cell_q, cell_d;
  logic     hit;
  logic [VAR_W-1:0] head;

  always_comb begin
    if (ctrl_i.binary) begin
      hit  = ((lset_i & var_bit(bin_i.first)) != '0) &&
             ((rset_i & var_bit(bin_i.second)) != '0);
      head = bin_i.head;
    end else begin
      hit  = (term_i.sym == token_i);
      head = term_i.head;
    end
    cell_d = cell_q;
    if (ctrl_i.clr) begin
      cell_d = '0;
    end else if (ctrl_i.en && hit) begin
      cell_d = cell_q | var_bit(head);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q <= '0;
    end else begin
      cell_q <= cell_d;
    end
  end

  assign cell_o = cell_q;

endmodule
`default_nettype wire

// ===== rtl/cyk_cnf_recognizer.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cyk_cnf_recognizer
// cyk recogniser for a grammar in chomsky normal form
// ----------------------------------------------------------------------------
// load and token requests are taken without a stall and give no result
// a finish request stalls input while the chart is filled and the start variable is tested,
// and longer while the result is stalled
// rules are tested one at a time in the shared rule unit: address, then ram data
// an empty sentence goes straight to the result state and is rejected
// reset clears counts, overflow flag and start variable; stores are read only where written
module cyk_cnf_recognizer import cyk_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [VAR_W-1:0]     cfg_wdata_i,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire logic [1:0]           opcode_i,
  input  wire logic [VAR_W-1:0]     left_variable_i,
  input  wire logic [VAR_W-1:0]     right_first_i,
  input  wire logic [VAR_W-1:0]     right_second_i,
  input  wire logic [SYM_IN_W-1:0]  symbol_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic                      accepted_o,
  output logic                      overflow_o
);

  // sequencer states
  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_TSYM  = 5'd1;  // read token i
  localparam logic [4:0] S_TTOK  = 5'd2;  // capture token
  localparam logic [4:0] S_TRD   = 5'd3;  // read terminal rule
  localparam logic [4:0] S_TEV   = 5'd4;  // test terminal rule
  localparam logic [4:0] S_TWR   = 5'd5;  // write bottom row cell
  localparam logic [4:0] S_CELL  = 5'd6;  // start a cell
  localparam logic [4:0] S_LRD   = 5'd7;  // read left sub-span
  localparam logic [4:0] S_RRD   = 5'd8;  // capture left, read right
  localparam logic [4:0] S_RWT   = 5'd9;  // capture right
  localparam logic [4:0] S_BRD   = 5'd10; // read binary rule
  localparam logic [4:0] S_BEV   = 5'd11; // test binary rule
  localparam logic [4:0] S_CUTNX = 5'd12; // next split point
  localparam logic [4:0] S_CWR   = 5'd13; // write cell
  localparam logic [4:0] S_FINAL = 5'd14; // read top cell
  localparam logic [4:0] S_FRES  = 5'd15; // test start variable
  localparam logic [4:0] S_OUT   = 5'd16; // hand result over

  logic [4:0] state_q, state_d;

  logic [VAR_W-1:0]   start_q;
  logic [RULE_CW-1:0] tcnt_q, tcnt_d, bcnt_q, bcnt_d;
  logic [TOK_CW-1:0]  n_q, n_d;
  logic               ovf_q, ovf_d;

  logic [TOK_CW-1:0]  i_q, i_d, span_q, span_d, begin_q, begin_d, cut_q, cut_d;
  logic [RULE_CW-1:0] r_q, r_d;
  logic [SYMBOL_BITS-1:0] tok_q, tok_d;
  var_set_t           lset_q, lset_d, rset_q, rset_d;
  logic               res_q, res_d;

  logic               out_valid_q, out_acc_q, out_ovf_q;
  logic               in_acc, out_free;
  logic [SYMBOL_BITS-1:0] sym_in;

  // memory ports
  logic                term_we, bin_we, sent_we, chart_we;
  logic [RULE_AW-1:0]  rule_raddr;
  logic [TOK_AW-1:0]   sent_raddr;
  logic [CHART_AW-1:0] chart_raddr, chart_waddr;
  term_rule_t          term_wdata, term_rdata;
  bin_rule_t           bin_wdata, bin_rdata;
  logic [SYMBOL_BITS-1:0] sent_rdata;
  var_set_t            chart_rdata, cell_set;
  ru_ctrl_t            ru_ctrl;

  // chart index arithmetic
  logic [TOK_CW-1:0] span_m1, cut_m1, rrow, rcol, nm1;

  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != S_IDLE);
  assign sym_in   = SYMBOL_BITS'(symbol_i);

  assign span_m1 = span_q - 1'b1;
  assign cut_m1  = cut_q - 1'b1;
  assign rrow    = span_q - cut_q - 1'b1;
  assign rcol    = begin_q + cut_q;
  assign nm1     = n_q - 1'b1;

  // loads write the rule and token stores at the current fill count
  assign term_we    = in_acc && (opcode_i == OP_LOAD_TERM) &&
                      (tcnt_q < RULE_CW'(MAX_RULES));
  assign bin_we     = in_acc && (opcode_i == OP_LOAD_BIN) &&
                      (bcnt_q < RULE_CW'(MAX_RULES));
  assign sent_we    = in_acc && (opcode_i == OP_TOKEN) && (n_q < TOK_CW'(MAX_TOKENS));
  assign term_wdata = '{head: left_variable_i, sym: sym_in};
  assign bin_wdata  = '{head: left_variable_i, first: right_first_i,
                        second: right_second_i};
  assign rule_raddr = r_q[RULE_AW-1:0];
  assign sent_raddr = i_q[TOK_AW-1:0];

  always_comb begin
    chart_we    = 1'b0;
    chart_waddr = {span_m1[TOK_AW-1:0], begin_q[TOK_AW-1:0]};
    chart_raddr = '0;
    ru_ctrl     = '{clr: 1'b0, en: 1'b0, binary: 1'b0};
    case (state_q)
      S_TTOK:  ru_ctrl.clr = 1'b1;
      S_TEV:   ru_ctrl.en  = 1'b1;
      S_TWR: begin
        chart_we    = 1'b1;
        chart_waddr = {TOK_AW'(0), i_q[TOK_AW-1:0]};
      end
      S_CELL:  ru_ctrl = '{clr: 1'b1, en: 1'b0, binary: 1'b1};
      S_LRD:   chart_raddr = {cut_m1[TOK_AW-1:0], begin_q[TOK_AW-1:0]};
      S_RRD:   chart_raddr = {rrow[TOK_AW-1:0], rcol[TOK_AW-1:0]};
      S_BEV:   ru_ctrl = '{clr: 1'b0, en: 1'b1, binary: 1'b1};
      S_CWR:   chart_we = 1'b1;
      S_FINAL: chart_raddr = {nm1[TOK_AW-1:0], TOK_AW'(0)};
      default: ;
    endcase
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    tcnt_d  = tcnt_q;
    bcnt_d  = bcnt_q;
    n_d     = n_q;
    ovf_d   = ovf_q;
    i_d     = i_q;
    span_d  = span_q;
    begin_d = begin_q;
    cut_d   = cut_q;
    r_d     = r_q;
    tok_d   = tok_q;
    lset_d  = lset_q;
    rset_d  = rset_q;
    res_d   = res_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          case (opcode_i)
            OP_LOAD_TERM: begin
              if (term_we) tcnt_d = tcnt_q + 1'b1;
              else         ovf_d  = 1'b1;
            end
            OP_LOAD_BIN: begin
              if (bin_we) bcnt_d = bcnt_q + 1'b1;
              else        ovf_d  = 1'b1;
            end
            OP_TOKEN: begin
              if (sent_we) n_d   = n_q + 1'b1;
              else         ovf_d = 1'b1;
            end
            default: begin
              i_d = '0;
              if (n_q == '0) begin
                res_d   = 1'b0;
                state_d = S_OUT;
              end else begin
                state_d = S_TSYM;
              end
            end
          endcase
        end
      end
      S_TSYM: state_d = S_TTOK;
      S_TTOK: begin
        tok_d   = sent_rdata;
        r_d     = '0;
        state_d = (tcnt_q == '0) ? S_TWR : S_TRD;
      end
      S_TRD: state_d = S_TEV;
      S_TEV: begin
        r_d     = r_q + 1'b1;
        state_d = (r_q + 1'b1 == tcnt_q) ? S_TWR : S_TRD;
      end
      S_TWR: begin
        i_d = i_q + 1'b1;
        if (i_q + 1'b1 == n_q) begin
          span_d  = TOK_CW'(2);
          begin_d = '0;
          state_d = (n_q == TOK_CW'(1)) ? S_FINAL : S_CELL;
        end else begin
          state_d = S_TSYM;
        end
      end
      S_CELL: begin
        cut_d   = TOK_CW'(1);
        state_d = S_LRD;
      end
      S_LRD: state_d = S_RRD;
      S_RRD: begin
        lset_d  = chart_rdata;
        state_d = S_RWT;
      end
      S_RWT: begin
        rset_d  = chart_rdata;
        r_d     = '0;
        state_d = (bcnt_q == '0) ? S_CUTNX : S_BRD;
      end
      S_BRD: state_d = S_BEV;
      S_BEV: begin
        r_d     = r_q + 1'b1;
        state_d = (r_q + 1'b1 == bcnt_q) ? S_CUTNX : S_BRD;
      end
      S_CUTNX: begin
        if (cut_q + 1'b1 == span_q) begin
          state_d = S_CWR;
        end else begin
          cut_d   = cut_q + 1'b1;
          state_d = S_LRD;
        end
      end
      S_CWR: begin
        if (begin_q + span_q == n_q) begin
          if (span_q == n_q) begin
            state_d = S_FINAL;
          end else begin
            span_d  = span_q + 1'b1;
            begin_d = '0;
            state_d = S_CELL;
          end
        end else begin
          begin_d = begin_q + 1'b1;
          state_d = S_CELL;
        end
      end
      S_FINAL: state_d = S_FRES;
      S_FRES: begin
        res_d   = ((chart_rdata & var_bit(start_q)) != '0);
        state_d = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          n_d     = '0;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      start_q     <= '0;
      tcnt_q      <= '0;
      bcnt_q      <= '0;
      n_q         <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      tcnt_q  <= tcnt_d;
      bcnt_q  <= bcnt_d;
      n_q     <= n_d;
      ovf_q   <= ovf_d;
      if (cfg_we_i) begin
        start_q <= cfg_wdata_i;
      end
      // result register: loaded when the parse ends, held while stalled
      if (state_q == S_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath registers, no reset needed
  always_ff @(posedge clk_i) begin
    i_q     <= i_d;
    span_q  <= span_d;
    begin_q <= begin_d;
    cut_q   <= cut_d;
    r_q     <= r_d;
    tok_q   <= tok_d;
    lset_q  <= lset_d;
    rset_q  <= rset_d;
    res_q   <= res_d;
    if (state_q == S_OUT && out_free) begin
      out_acc_q <= res_q;
      out_ovf_q <= ovf_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign accepted_o  = out_acc_q;
  assign overflow_o  = out_ovf_q;

  cyk_ram #(.WIDTH($bits(term_rule_t)), .DEPTH(MAX_RULES)) u_term_ram (
    .clk_i   (clk_i),
    .we_i    (term_we),
    .waddr_i (tcnt_q[RULE_AW-1:0]),
    .wdata_i (term_wdata),
    .raddr_i (rule_raddr),
    .rdata_o (term_rdata)
  );

  cyk_ram #(.WIDTH($bits(bin_rule_t)), .DEPTH(MAX_RULES)) u_bin_ram (
    .clk_i   (clk_i),
    .we_i    (bin_we),
    .waddr_i (bcnt_q[RULE_AW-1:0]),
    .wdata_i (bin_wdata),
    .raddr_i (rule_raddr),
    .rdata_o (bin_rdata)
  );

  cyk_ram #(.WIDTH(SYMBOL_BITS), .DEPTH(MAX_TOKENS)) u_sent_ram (
    .clk_i   (clk_i),
    .we_i    (sent_we),
    .waddr_i (n_q[TOK_AW-1:0]),
    .wdata_i (sym_in),
    .raddr_i (sent_raddr),
    .rdata_o (sent_rdata)
  );

  // chart row is span minus one, column is the span's first token
  cyk_ram #(.WIDTH(MAX_VARIABLES), .DEPTH(1 << CHART_AW)) u_chart_ram (
    .clk_i   (clk_i),
    .we_i    (chart_we),
    .waddr_i (chart_waddr),
    .wdata_i (cell_set),
    .raddr_i (chart_raddr),
    .rdata_o (chart_rdata)
  );

  cyk_rule_unit u_rule_unit (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (ru_ctrl),
    .token_i (tok_q),
    .term_i  (term_rdata),
    .bin_i   (bin_rdata),
    .lset_i  (lset_q),
    .rset_i  (rset_q),
    .cell_o  (cell_set)
  );

endmodule
`default_nettype wire

// ===== test/cyk_cnf_recognizer_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cyk_cnf_recognizer_tb
// drives grammars and sentences into the cyk recogniser, runs its own chart
// fill for every finish request and compares accepted and overflow flags
// ----------------------------------------------------------------------------
module cyk_cnf_recognizer_tb;
  import cyk_pkg::*;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [VAR_W-1:0]    cfg_wdata_i = '0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic [1:0]          opcode_i = OP_LOAD_TERM;
  logic [VAR_W-1:0]    left_variable_i = '0;
  logic [VAR_W-1:0]    right_first_i = '0;
  logic [VAR_W-1:0]    right_second_i = '0;
  logic [SYM_IN_W-1:0] symbol_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic                accepted_o;
  logic                overflow_o;

  cyk_cnf_recognizer u_top (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i, .in_valid_i, .in_stall_o,
    .opcode_i, .left_variable_i, .right_first_i, .right_second_i, .symbol_i,
    .out_valid_o, .out_stall_i, .accepted_o, .overflow_o
  );

  always #4 clk_i = ~clk_i;

  // predictor state
  term_rule_t term_store[MAX_RULES];
  bin_rule_t  bin_store[MAX_RULES];
  int         term_cnt, bin_cnt, sent_len;
  logic [SYMBOL_BITS-1:0] sent[MAX_TOKENS];
  logic       ovf_seen;
  logic [VAR_W-1:0] start_var;
  var_set_t   chart_cells[MAX_TOKENS][MAX_TOKENS];

  typedef struct packed {
    logic accepted;
    logic overflow;
  } verdict_t;
  verdict_t pending_verdicts[$];
  int mismatches = 0;
  int burst_left = 0;
  int stall_mode = 0;

  function automatic var_set_t one_var(input logic [VAR_W-1:0] v);
    one_var = '0;
    if (int'(v) < MAX_VARIABLES) one_var[v] = 1'b1;
  endfunction

  // bottom-up chart fill of the current sentence
  function automatic logic derive_sentence();
    var_set_t acc_set, lset, rset;
    int n;
    n = sent_len;
    if (n == 0) return 1'b0;
    for (int i = 0; i < n; i++) begin
      chart_cells[0][i] = '0;
      for (int r = 0; r < term_cnt; r++)
        if (term_store[r].sym == sent[i]) chart_cells[0][i] |= one_var(term_store[r].head);
    end
    for (int span = 2; span <= n; span++)
      for (int b = 0; b + span <= n; b++) begin
        acc_set = '0;
        for (int cut = 1; cut < span; cut++) begin
          lset = chart_cells[cut-1][b];
          rset = chart_cells[span-cut-1][b+cut];
          for (int r = 0; r < bin_cnt; r++)
            if ((lset & one_var(bin_store[r].first)) != 0 &&
                (rset & one_var(bin_store[r].second)) != 0)
              acc_set |= one_var(bin_store[r].head);
        end
        chart_cells[span-1][b] = acc_set;
      end
    return (chart_cells[n-1][0] & one_var(start_var)) != 0;
  endfunction

  task automatic predict_request(input logic [1:0] op, input logic [VAR_W-1:0] lv, r1, r2,
                                 input logic [SYM_IN_W-1:0] sym);
    verdict_t v;
    case (op)
      OP_LOAD_TERM: begin
        if (term_cnt < MAX_RULES) begin
          term_store[term_cnt] = '{head: lv, sym: sym[SYMBOL_BITS-1:0]};
          term_cnt++;
        end else ovf_seen = 1'b1;
      end
      OP_LOAD_BIN: begin
        if (bin_cnt < MAX_RULES) begin
          bin_store[bin_cnt] = '{head: lv, first: r1, second: r2};
          bin_cnt++;
        end else ovf_seen = 1'b1;
      end
      OP_TOKEN: begin
        if (sent_len < MAX_TOKENS) begin
          sent[sent_len] = sym[SYMBOL_BITS-1:0];
          sent_len++;
        end else ovf_seen = 1'b1;
      end
      default: begin
        v.accepted = derive_sentence();
        v.overflow = ovf_seen;
        pending_verdicts = {pending_verdicts, v};
        sent_len = 0;
      end
    endcase
  endtask

  task automatic report_mismatch(input string what);
    $display("mismatch: %s", what);
    mismatches++;
  endtask

  // send one request, honouring bursts and gaps
  task automatic send_request(input logic [1:0] op, input int lv, r1, r2, sym);
    logic [VAR_W-1:0]    lv_b, r1_b, r2_b;
    logic [SYM_IN_W-1:0] sym_b;
    int                  gap;
    lv_b  = VAR_W'(lv);
    r1_b  = VAR_W'(r1);
    r2_b  = VAR_W'(r2);
    sym_b = SYM_IN_W'(sym);
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? int'($urandom_range(1, 3)) : 0;
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    in_valid_i      <= 1'b1;
    opcode_i        <= op;
    left_variable_i <= lv_b;
    right_first_i   <= r1_b;
    right_second_i  <= r2_b;
    symbol_i        <= sym_b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_request(op, lv_b, r1_b, r2_b, sym_b);
  endtask

  task automatic go_idle();
    in_valid_i <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (pending_verdicts.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic set_start(input int sv);
    go_idle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= VAR_W'(sv);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    start_var = VAR_W'(sv);
  endtask

  // receiver stall pattern; sample outputs at the edge
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_verdicts.size() == 0) report_mismatch("result with none expected");
      else begin
        verdict_t e;
        e = pending_verdicts.pop_front();
        if (accepted_o !== e.accepted)
          report_mismatch($sformatf("accepted %b, want %b", accepted_o, e.accepted));
        if (overflow_o !== e.overflow)
          report_mismatch($sformatf("overflow %b, want %b", overflow_o, e.overflow));
      end
    end
    case (stall_mode)
      0: out_stall_i <= 1'b0;
      1: out_stall_i <= ($urandom_range(0, 3) == 0);
      default: out_stall_i <= ($urandom_range(0, 1) == 0);
    endcase
  end

  // small grammar: a -> x, b -> y, s -> a b, s -> s s style relations
  task automatic test_directed();
    set_start(0);
    send_request(OP_FINISH, 0, 0, 0, 0);               // empty sentence
    send_request(OP_LOAD_TERM, 1, 0, 0, 0);
    send_request(OP_LOAD_TERM, 2, 0, 0, 255);
    send_request(OP_LOAD_TERM, 31, 0, 0, 255);
    send_request(OP_LOAD_BIN, 0, 1, 2, 0);
    send_request(OP_LOAD_BIN, 0, 0, 0, 0);
    send_request(OP_LOAD_BIN, 31, 31, 31, 0);
    send_request(OP_TOKEN, 0, 0, 0, 0);
    send_request(OP_TOKEN, 0, 0, 0, 255);
    send_request(OP_FINISH, 0, 0, 0, 0);
    send_request(OP_TOKEN, 0, 0, 0, 0);
    send_request(OP_FINISH, 0, 0, 0, 0);
    set_start(31);
    send_request(OP_TOKEN, 0, 0, 0, 255);
    send_request(OP_TOKEN, 0, 0, 0, 255);
    send_request(OP_FINISH, 0, 0, 0, 0);
  endtask

  task automatic random_sentence(input int len, input int nsym);
    for (int i = 0; i < len; i++) send_request(OP_TOKEN, $urandom, $urandom, $urandom,
                                               $urandom_range(0, nsym));
    send_request(OP_FINISH, $urandom, $urandom, $urandom, $urandom);
  endtask

  // random grammars over few variables and symbols so parses succeed often
  task automatic test_random_grammars();
    int nv;
    for (int g = 0; g < 6; g++) begin
      nv = $urandom_range(3, 6);
      for (int k = 0; k < 8; k++)
        send_request(OP_LOAD_TERM, $urandom_range(0, nv), $urandom, $urandom,
                     $urandom_range(0, 3));
      for (int k = 0; k < 9; k++)
        send_request(OP_LOAD_BIN, $urandom_range(0, nv), $urandom_range(0, nv),
                     $urandom_range(0, nv), $urandom);
      stall_mode = g % 3;
      set_start($urandom_range(0, nv));
      for (int s = 0; s < 29; s++) random_sentence($urandom_range(0, 8), 3);
    end
  endtask

  // fill both stores past capacity, then overflow the sentence
  task automatic test_overflow();
    while (term_cnt < MAX_RULES)
      send_request(OP_LOAD_TERM, $urandom, 0, 0, $urandom);
    repeat (2) send_request(OP_LOAD_TERM, $urandom, 0, 0, $urandom);
    while (bin_cnt < MAX_RULES) send_request(OP_LOAD_BIN, $urandom, $urandom, $urandom, 0);
    send_request(OP_LOAD_BIN, $urandom, $urandom, $urandom, 0);
    random_sentence(MAX_TOKENS + 2, 255);
    random_sentence(MAX_TOKENS, 3);
    for (int s = 0; s < 40; s++) random_sentence($urandom_range(0, 6), 255);
  endtask

  initial begin
    term_cnt = 0; bin_cnt = 0; sent_len = 0; ovf_seen = 1'b0; start_var = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random_grammars();
    test_overflow();
    go_idle();
    if (mismatches == 0 && pending_verdicts.size() == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end

  initial begin
    #200ms;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/cyk_pkg.sv
rtl/cyk_ram.sv
rtl/cyk_rule_unit.sv
rtl/cyk_cnf_recognizer.sv
test/cyk_cnf_recognizer_tb.sv
